// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("assert");
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("assert");
`else
`define ASSERT_IMPLY(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// File: hw/rtl/bbcs_pkg.sv
// Package with widths, constants and types of the box bounce block.
package bbcs_pkg;
   localparam int MaxBoxes = 64;
   localparam int IdxW = (MaxBoxes > 1) ? $clog2(MaxBoxes) : 1;
   localparam int CntW = $clog2(MaxBoxes + 1);
   localparam int PosW = 18;
   localparam int VelW = 12;
   localparam int SizeW = 16;
   localparam int ScrW = 9;
   localparam int CsrIdxW = 1;
   localparam int CsrDataW = 9;
   localparam logic [CsrIdxW-1:0] CSR_WIDTH = 1'b0;
   localparam logic [CsrIdxW-1:0] CSR_HEIGHT = 1'b1;
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_TICK = 1'b1;
   localparam logic signed [PosW-1:0] POS_MAX = 18'sh1FFFF;
   localparam logic signed [PosW-1:0] POS_MIN = -18'sh20000;
   localparam logic signed [VelW-1:0] VEL_MAX = 12'sh7FF;
   localparam logic signed [VelW-1:0] VEL_MIN = -12'sh800;

   typedef struct packed {
      logic [PosW-1:0] px;
      logic [PosW-1:0] py;
      logic [VelW-1:0] vx;
      logic [VelW-1:0] vy;
      logic [SizeW-1:0] w;
      logic [SizeW-1:0] h;
   } box_type;

   // Datapath commands from the controller.
   typedef struct packed {
      logic load;       // write the load request into its slot
      logic rd_i;       // read box i into the working registers
      logic step_i;     // move and bounce box i
      logic rd_j;       // read box j
      logic pair;       // collide box i with box j, write j back
      logic wr_i;       // write box i back and capture the response
      logic [IdxW-1:0] i;
      logic [IdxW-1:0] j;
   } cmd_type;

   function automatic logic signed [PosW-1:0] sat_pos(input logic signed [21:0] v);
      if (v > 22'(POS_MAX)) return POS_MAX;
      if (v < 22'(POS_MIN)) return POS_MIN;
      return v[PosW-1:0];
   endfunction

   function automatic logic signed [VelW-1:0] neg_vel(input logic signed [VelW-1:0] v);
      if (v == VEL_MIN) return VEL_MAX;
      return -v;
   endfunction
endpackage

// File: hw/rtl/bbcs_req_if.sv
// Valid/ready channel interfaces for requests and responses.
interface bbcs_req_if;
   import bbcs_pkg::*;
   logic valid;
   logic ready;
   logic action;
   logic [IdxW-1:0] box_index;
   logic signed [PosW-1:0] pos_x;
   logic signed [PosW-1:0] pos_y;
   logic signed [VelW-1:0] vel_x;
   logic signed [VelW-1:0] vel_y;
   logic [SizeW-1:0] size_w;
   logic [SizeW-1:0] size_h;
   logic [CntW-1:0] active_count;
   modport source (output valid, action, box_index, pos_x, pos_y, vel_x, vel_y,
      size_w, size_h, active_count, input ready);
   modport sink (input valid, action, box_index, pos_x, pos_y, vel_x, vel_y,
      size_w, size_h, active_count, output ready);
endinterface

interface bbcs_rsp_if;
   import bbcs_pkg::*;
   logic valid;
   logic ready;
   logic [IdxW-1:0] out_index;
   logic signed [PosW-1:0] out_x;
   logic signed [PosW-1:0] out_y;
   logic last;
   modport source (output valid, out_index, out_x, out_y, last, input ready);
   modport sink (input valid, out_index, out_x, out_y, last, output ready);
endinterface

// File: hw/rtl/bbcs_datapath.sv
// Datapath: box memory, working box registers, bounce and collision arithmetic.
module bbcs_datapath (
   input  logic clock,
   input  bbcs_pkg::cmd_type cmd,
   input  bbcs_pkg::box_type load_box,
   input  logic [bbcs_pkg::ScrW-1:0] scr_w,
   input  logic [bbcs_pkg::ScrW-1:0] scr_h,
   output logic signed [bbcs_pkg::PosW-1:0] res_x,
   output logic signed [bbcs_pkg::PosW-1:0] res_y
);
   import bbcs_pkg::*;

   box_type mem [MaxBoxes];
   box_type rd_ff;
   box_type bi_ff, bi_in;
   box_type bj;
   // Pre-move extent of box i.
   logic signed [19:0] x1min_ff, x1max_ff, y1min_ff, y1max_ff;
   logic signed [PosW-1:0] res_x_ff, res_y_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) mem[cmd.i] <= load_box;
      if (cmd.pair) mem[cmd.j] <= bj;
      if (cmd.wr_i) mem[cmd.i] <= bi_ff;
      if (cmd.rd_i) rd_ff <= mem[cmd.i];
      else if (cmd.rd_j) rd_ff <= mem[cmd.j];
   end

   // Step of box i and pairwise collision, both work on bi.
   logic signed [19:0] x, y, w, h, sw, sh;
   logic signed [19:0] x2min, x2max, y2min, y2max;
   logic signed [20:0] rd, ld, td, bd, mn;
   logic [1:0] sel;
   logic ovl;
   logic signed [VelW-1:0] vx, vy;

   function automatic logic signed [20:0] absd(input logic signed [20:0] v);
      return (v < 0) ? -v : v;
   endfunction

   always_comb begin
      bi_in = bi_ff;
      bj = rd_ff;
      x = 20'(signed'(rd_ff.px));
      y = 20'(signed'(rd_ff.py));
      w = 20'(rd_ff.w);
      h = 20'(rd_ff.h);
      sw = 20'({scr_w, 8'd0});
      sh = 20'({scr_h, 8'd0});
      vx = rd_ff.vx;
      vy = rd_ff.vy;
      x2min = x; x2max = x + w; y2min = y; y2max = y + h;
      rd = absd(21'(x1max_ff) - 21'(x2min)) + 21'sd256;
      ld = absd(21'(x1min_ff) - 21'(x2max)) + 21'sd256;
      td = absd(21'(y1min_ff) - 21'(y2max)) + 21'sd256;
      bd = absd(21'(y1max_ff) - 21'(y2min)) + 21'sd256;
      ovl = (x1min_ff < x2max) && (x2min < x1max_ff) && (y1min_ff < y2max)
         && (y2min < y1max_ff);
      mn = rd;
      if (ld < mn) mn = ld;
      if (td < mn) mn = td;
      if (bd < mn) mn = bd;
      sel = 2'd0;
      if (mn == ld) sel = 2'd1;
      if (mn == td) sel = 2'd2;
      if (mn == bd) sel = 2'd3;
      if (cmd.step_i) begin
         bi_in = rd_ff;
         bi_in.px = sat_pos(22'(x) + 22'(signed'(vx)));
         bi_in.py = sat_pos(22'(y) + 22'(signed'(vy)));
         if (x <= 0) begin vx = neg_vel(vx); bi_in.px = 18'sd256; end
         if (y <= 0) begin vy = neg_vel(vy); bi_in.py = 18'sd256; end
         if (x >= sw - w) begin
            vx = neg_vel(vx);
            bi_in.px = sat_pos(22'(sw) - 22'(w) - 22'sd256);
         end
         if (y >= sh - h) begin
            vy = neg_vel(vy);
            bi_in.py = sat_pos(22'(sh) - 22'(h) - 22'sd256);
         end
         bi_in.vx = vx;
         bi_in.vy = vy;
      end else if (cmd.pair && ovl) begin
         case (sel)
            2'd0: begin
               bi_in.px = sat_pos(22'(signed'(bi_ff.px)) - 22'(rd >>> 1));
               bj.px = sat_pos(22'(signed'(rd_ff.px)) + 22'(rd >>> 1));
               bi_in.vx = rd_ff.vx; bj.vx = bi_ff.vx;
            end
            2'd1: begin
               bi_in.px = sat_pos(22'(signed'(bi_ff.px)) + 22'(ld >>> 1));
               bj.px = sat_pos(22'(signed'(rd_ff.px)) - 22'(ld >>> 1));
               bi_in.vx = rd_ff.vx; bj.vx = bi_ff.vx;
            end
            2'd2: begin
               bi_in.py = sat_pos(22'(signed'(bi_ff.py)) + 22'(td >>> 1));
               bj.py = sat_pos(22'(signed'(rd_ff.py)) - 22'(td >>> 1));
               bi_in.vy = rd_ff.vy; bj.vy = bi_ff.vy;
            end
            default: begin
               bi_in.py = sat_pos(22'(signed'(bi_ff.py)) - 22'(bd >>> 1));
               bj.py = sat_pos(22'(signed'(rd_ff.py)) + 22'(bd >>> 1));
               bi_in.vy = rd_ff.vy; bj.vy = bi_ff.vy;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      bi_ff <= bi_in;
      if (cmd.step_i) begin
         x1min_ff <= x; x1max_ff <= x + w; y1min_ff <= y; y1max_ff <= y + h;
      end
      if (cmd.wr_i) begin
         res_x_ff <= bi_ff.px;
         res_y_ff <= bi_ff.py;
      end
   end

   assign res_x = res_x_ff;
   assign res_y = res_y_ff;
endmodule

// File: hw/rtl/bbcs_ctrl.sv
// Controller: sequences loads, per-box steps, pair checks and responses.
module bbcs_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_fire,
   input  logic req_action,
   input  logic [bbcs_pkg::IdxW-1:0] req_index,
   input  logic [bbcs_pkg::CntW-1:0] req_count,
   input  logic rsp_ready,
   output logic req_ready,
   output logic rsp_valid,
   output logic [bbcs_pkg::IdxW-1:0] rsp_index,
   output logic rsp_last,
   output bbcs_pkg::cmd_type cmd
);
   import bbcs_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RDI = 3'd1;
   localparam logic [2:0] ST_STEP = 3'd2;
   localparam logic [2:0] ST_RDJ = 3'd3;
   localparam logic [2:0] ST_PAIR = 3'd4;
   localparam logic [2:0] ST_WR = 3'd5;
   localparam logic [2:0] ST_OUT = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [CntW-1:0] cnt_ff, cnt_in, i_ff, i_in, j_ff, j_in;
   logic [CntW-1:0] cnt_sat;

   assign cnt_sat = (req_count > CntW'(MaxBoxes)) ? CntW'(MaxBoxes) : req_count;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff; i_in = i_ff; j_in = j_ff;
      cmd = '0;
      cmd.i = i_ff[IdxW-1:0];
      cmd.j = j_ff[IdxW-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_action == ACT_LOAD) begin
                  cmd.load = 1'b1;
                  cmd.i = req_index;
               end else if (cnt_sat != '0) begin
                  cnt_in = cnt_sat; i_in = '0; state_in = ST_RDI;
               end
            end
         end
         ST_RDI: begin cmd.rd_i = 1'b1; state_in = ST_STEP; end
         ST_STEP: begin
            cmd.step_i = 1'b1;
            j_in = i_ff + 1'b1;
            state_in = (i_ff + 1'b1 < cnt_ff) ? ST_RDJ : ST_WR;
         end
         ST_RDJ: begin cmd.rd_j = 1'b1; state_in = ST_PAIR; end
         ST_PAIR: begin
            cmd.pair = 1'b1;
            j_in = j_ff + 1'b1;
            state_in = (j_ff + 1'b1 < cnt_ff) ? ST_RDJ : ST_WR;
         end
         ST_WR: begin cmd.wr_i = 1'b1; state_in = ST_OUT; end
         ST_OUT: begin
            if (rsp_ready) begin
               i_in = i_ff + 1'b1;
               state_in = (i_ff + 1'b1 < cnt_ff) ? ST_RDI : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
      cnt_ff <= cnt_in; i_ff <= i_in; j_ff <= j_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_index = i_ff[IdxW-1:0];
   assign rsp_last = (i_ff + 1'b1 == cnt_ff);
endmodule

// File: hw/rtl/box_bounce_collision_step.sv
// Top level of the box bounce and collision step block.
//
//   channel   direction  contents
//   req       in         load of one box, or one frame tick
//   rsp       out        final position of each updated box
//   csr       in         screen width and height writes
//
// A tick steps each box in turn and checks it against every later box, one pair
// at a time through the single read port of the box memory:
// each pair check reads box j, then updates and writes it back.
// Reset is synchronous and clears the controller; the box memory is not cleared.
// A response stall holds the controller in its output state.
module box_bounce_collision_step (
   input logic clock,
   input logic reset,
   bbcs_req_if.sink req,
   bbcs_rsp_if.source rsp,
   input logic csr_write_enable,
   input logic [bbcs_pkg::CsrIdxW-1:0] csr_index,
   input logic [bbcs_pkg::CsrDataW-1:0] csr_write_data
);
   import bbcs_pkg::*;
   `include "assert_macros.svh"

   logic [ScrW-1:0] scr_w_ff, scr_h_ff;
   cmd_type cmd;
   box_type load_box;
   logic req_fire;

   // Screen size registers; the index is only one bit wide so every write lands.
   always_ff @(posedge clock) begin
      if (reset) begin
         scr_w_ff <= 9'd400;
         scr_h_ff <= 9'd240;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_WIDTH) scr_w_ff <= csr_write_data;
         if (csr_index == CSR_HEIGHT) scr_h_ff <= csr_write_data;
      end
   end

   assign req_fire = req.valid && req.ready;
   assign load_box = '{px: req.pos_x, py: req.pos_y, vx: req.vel_x, vy: req.vel_y,
      w: req.size_w, h: req.size_h};

   bbcs_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req_fire), .req_action(req.action),
      .req_index(req.box_index), .req_count(req.active_count), .rsp_ready(rsp.ready),
      .req_ready(req.ready), .rsp_valid(rsp.valid), .rsp_index(rsp.out_index),
      .rsp_last(rsp.last), .cmd(cmd)
   );

   bbcs_datapath u_dp (
      .clock(clock), .cmd(cmd), .load_box(load_box), .scr_w(scr_w_ff),
      .scr_h(scr_h_ff), .res_x(rsp.out_x), .res_y(rsp.out_y)
   );

   // A request is never taken while a response is pending.
   `ASSERT_IMPLY(a_no_overlap, clock, reset, rsp.valid, !req.ready)
   // At most one datapath command is active in any cycle.
   `ASSERT_IMPLY(a_cmd_onehot, clock, reset, 1'b1,
      $onehot0({cmd.load, cmd.rd_i, cmd.step_i, cmd.rd_j, cmd.pair, cmd.wr_i}))
   // A write-back of box i is followed by its response.
   `ASSERT_NEXT(a_wr_rsp, clock, reset, cmd.wr_i, rsp.valid)
endmodule
